// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL file random_permutation_shuffle.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Implication whose consequence is checked in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/rps_pkg.sv =====
package rps_pkg;

  localparam int unsigned OPCODE_W   = 1;
  localparam int unsigned POSITION_W = 12;
  localparam int unsigned INDEX_W    = 12;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SEED_W     = 64;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned CFG_DATA_W = 64;

  // Table size; the position and index fields are sized for it.
  localparam int unsigned MAX_RECORDS = 4096;

  // Generator constants.
  localparam logic [63:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;
  localparam int unsigned SHIFT_0    = 30;
  localparam int unsigned SHIFT_1    = 27;
  localparam int unsigned SHIFT_2    = 31;

  typedef enum logic [0:0] {
    OP_SHUFFLE = 1'b0,
    OP_READ    = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOT_SHUF = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CFG_SEED  = 1'b0,
    CFG_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_FILL,
    S_RNG,
    S_MUL_A,
    S_MUL_B,
    S_DIV,
    S_SW_RI,
    S_SW_RJ,
    S_SW_WI,
    S_SW_WJ
  } state_e;

  typedef struct packed {
    opcode_e                 opcode;
    logic [POSITION_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0]      record_index;
    status_e                 status;
  } rsp_t;

endpackage

// ===== rtl/rps_ram.sv =====
module rps_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/random_permutation_shuffle.sv =====
// Read transaction: accept, registered table read (S_RD_WAIT), registered result strobe;
// an error status skips the table read. Shuffle transaction: identity fill of the
// n entries, then per swap step one add, 3 + 3 32x32 partial products, a bit-serial
// remainder over the 64 bits and 4 table accesses; one at a time.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset is asynchronous and clears control state; the table needs no clearing.
`include "assert_macros.svh"

module random_permutation_shuffle (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  rps_pkg::req_t                       req_i,
  output logic                                done_o,
  output rps_pkg::rsp_t                       rsp_o,
  input  logic                                cfg_we_i,
  input  rps_pkg::cfg_idx_e                   cfg_idx_i,
  input  logic [rps_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import rps_pkg::*;

  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned WW = (CW > COUNT_W) ? CW : COUNT_W;

  state_e               state_q, state_d;
  logic [SEED_W-1:0]    seed_q;
  logic [COUNT_W-1:0]   count_q;
  logic                 valid_q, valid_d;
  logic                 done_q, done_d;
  rsp_t                 rsp_q, rsp_d;
  logic [AW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        i_q, i_d;
  logic [AW-1:0]        j_q, j_d;
  logic [AW-1:0]        ti_q, ti_d;
  logic [63:0]          rng_q, rng_d;
  logic [63:0]          z_q, z_d;
  logic [63:0]          acc_q, acc_d;
  logic [1:0]           phase_q, phase_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic [5:0]           bit_q, bit_d;

  logic [CW-1:0]        n_eff;
  logic [63:0]          rng_next;
  logic [63:0]          mul_k;
  logic [31:0]          mul_a, mul_b;
  logic [63:0]          prod, acc_sum;
  logic [CW:0]          div_shift, div_dvs;
  logic [CW-1:0]        rem_next;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [AW-1:0]        ram_wdata, ram_rdata;

  rps_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_RECORDS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Effective record count, saturated into 1..MAX_RECORDS.
  always_comb begin
    if (count_q == '0) begin
      n_eff = CW'(1);
    end else if (WW'(count_q) > WW'(MAX_RECORDS)) begin
      n_eff = CW'(MAX_RECORDS);
    end else begin
      n_eff = CW'(count_q);
    end
  end

  // Shared 32x32 multiplier; three partial products build the low 64 bits.
  assign mul_k   = (state_q == S_MUL_A) ? MIX_MUL_A : MIX_MUL_B;
  assign mul_a   = (phase_q == 2'd2) ? z_q[63:32] : z_q[31:0];
  assign mul_b   = (phase_q == 2'd1) ? mul_k[63:32] : mul_k[31:0];
  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign acc_sum = (phase_q == 2'd0) ? prod : (acc_q + {prod[31:0], 32'd0});

  assign rng_next = rng_q + GOLDEN_INC;

  // One restoring remainder step per cycle, divisor i+1.
  assign div_shift = {rem_q, z_q[63]};
  assign div_dvs   = (CW+1)'(i_q) + (CW+1)'(1);
  assign rem_next  = (div_shift >= div_dvs) ? CW'(div_shift - div_dvs) : CW'(div_shift);

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      done_q  <= 1'b0;
      rng_q   <= '0;
      phase_q <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      done_q  <= done_d;
      rng_q   <= rng_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      count_q <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEED:  seed_q  <= cfg_data_i[SEED_W-1:0];
        CFG_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        default:   seed_q  <= seed_q;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    cnt_q <= cnt_d;
    i_q   <= i_d;
    j_q   <= j_d;
    ti_q  <= ti_d;
    z_q   <= z_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  // Next state, datapath updates and table accesses.
  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    j_d       = j_q;
    ti_d      = ti_q;
    rng_d     = rng_q;
    z_d       = z_q;
    acc_d     = acc_q;
    phase_d   = phase_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = cnt_q;
    ram_raddr = AW'(req_i.position);

    if (cfg_we_i && (cfg_idx_i == CFG_COUNT)) begin
      valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_i.opcode == OP_SHUFFLE) begin
            cnt_d   = '0;
            state_d = S_FILL;
          end else if (!valid_q) begin
            done_d = 1'b1;
            rsp_d  = '{record_index: '0, status: ST_NOT_SHUF};
          end else if (WW'(req_i.position) >= WW'(n_eff)) begin
            done_d = 1'b1;
            rsp_d  = '{record_index: '0, status: ST_RANGE};
          end else begin
            state_d = S_RD_WAIT;
          end
        end
      end
      S_RD_WAIT: begin
        done_d  = 1'b1;
        rsp_d   = '{record_index: INDEX_W'(ram_rdata), status: ST_OK};
        state_d = S_IDLE;
      end
      S_FILL: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + AW'(1);
        if (cnt_q == AW'(n_eff - CW'(1))) begin
          rng_d = (seed_q == '0) ? 64'd1 : seed_q;
          i_d   = cnt_q;
          if (cnt_q == '0) begin
            valid_d = 1'b1;
            done_d  = 1'b1;
            rsp_d   = '{record_index: '0, status: ST_OK};
            state_d = S_IDLE;
          end else begin
            state_d = S_RNG;
          end
        end
      end
      S_RNG: begin
        rng_d   = rng_next;
        z_d     = rng_next ^ (rng_next >> SHIFT_0);
        phase_d = 2'd0;
        state_d = S_MUL_A;
      end
      S_MUL_A: begin
        acc_d   = acc_sum;
        phase_d = phase_q + 2'd1;
        if (phase_q == 2'd2) begin
          z_d     = acc_sum ^ (acc_sum >> SHIFT_1);
          phase_d = 2'd0;
          state_d = S_MUL_B;
        end
      end
      S_MUL_B: begin
        acc_d   = acc_sum;
        phase_d = phase_q + 2'd1;
        if (phase_q == 2'd2) begin
          z_d     = acc_sum ^ (acc_sum >> SHIFT_2);
          phase_d = 2'd0;
          rem_d   = '0;
          bit_d   = 6'd63;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = rem_next;
        z_d   = {z_q[62:0], 1'b0};
        bit_d = bit_q - 6'd1;
        if (bit_q == '0) begin
          j_d     = AW'(rem_next);
          state_d = S_SW_RI;
        end
      end
      S_SW_RI: begin
        ram_raddr = i_q;
        state_d   = S_SW_RJ;
      end
      S_SW_RJ: begin
        ram_raddr = j_q;
        ti_d      = ram_rdata;
        state_d   = S_SW_WI;
      end
      S_SW_WI: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
        state_d   = S_SW_WJ;
      end
      S_SW_WJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = ti_q;
        if (i_q == AW'(1)) begin
          i_d     = '0;
          valid_d = 1'b1;
          done_d  = 1'b1;
          rsp_d   = '{record_index: '0, status: ST_OK};
          state_d = S_IDLE;
        end else begin
          i_d     = i_q - AW'(1);
          state_d = S_RNG;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Checks on the sequencer and datapath.
  `ASSERT_IMPLIES(a_err_zero_idx, clk_i, rst_ni, done_o && (rsp_o.status != ST_OK),
                  rsp_o.record_index == '0)
  `ASSERT_IMPLIES(a_rem_below_dvs, clk_i, rst_ni, state_q == S_DIV,
                  (CW+1)'(rem_q) < div_dvs)
  `ASSERT_IMPLIES(a_swap_order, clk_i, rst_ni,
                  (state_q == S_SW_RI) || (state_q == S_SW_WJ), j_q <= i_q)
  `ASSERT_NEXT(a_shuffle_busy, clk_i, rst_ni,
               start && !busy && (req_i.opcode == OP_SHUFFLE), busy)

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import rps_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;
  logic cfg_we_i;
  cfg_idx_e cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  random_permutation_shuffle uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the block state used to work out expected results.
  logic [63:0] seed_reg;
  logic [12:0] count_reg;
  logic [11:0] perm_copy [4096];
  logic        perm_ready;
  rsp_t        pending_rsp_q[$];
  int          error_count;
  int          items_sent;
  bit          calm;

  // Count after saturation to the supported range.
  function automatic int active_count();
    if (count_reg == 0) return 1;
    if (count_reg > 4096) return 4096;
    return int'(count_reg);
  endfunction

  // Rebuild the permutation as the block does: identity, then a
  // Fisher-Yates pass fed by splitmix64.
  task automatic rebuild_perm();
    int n;
    int j;
    logic [63:0] gen;
    logic [63:0] z;
    logic [11:0] tmp;
    n = active_count();
    for (int k = 0; k < n; k++) perm_copy[k] = k[11:0];
    gen = (seed_reg == 0) ? 64'd1 : seed_reg;
    for (int i = n - 1; i > 0; i--) begin
      gen = gen + GOLDEN_INC;
      z = gen;
      z = (z ^ (z >> SHIFT_0)) * MIX_MUL_A;
      z = (z ^ (z >> SHIFT_1)) * MIX_MUL_B;
      z = z ^ (z >> SHIFT_2);
      j = int'(z % (i + 1));
      tmp = perm_copy[i];
      perm_copy[i] = perm_copy[j];
      perm_copy[j] = tmp;
    end
    perm_ready = 1'b1;
  endtask

  // Expected response for one accepted command.
  task automatic predict_rsp(input req_t cmd, output rsp_t rsp);
    rsp.record_index = '0;
    rsp.status = ST_OK;
    if (cmd.opcode == OP_SHUFFLE) begin
      rebuild_perm();
    end else if (!perm_ready) begin
      rsp.status = ST_NOT_SHUF;
    end else if (cmd.position >= active_count()) begin
      rsp.status = ST_RANGE;
    end else begin
      rsp.record_index = perm_copy[cmd.position];
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Response checker: every strobed result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("response with no command outstanding");
      end else begin
        rsp_t want;
        want = pending_rsp_q.pop_front();
        if (rsp_o.record_index !== want.record_index)
          report_mismatch($sformatf("record_index got %0d want %0d",
                                    rsp_o.record_index, want.record_index));
        if (rsp_o.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp_o.status, want.status));
      end
    end
  end

  // Release all request lines and wait for the given number of cycles.
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    cfg_we_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Wait until every expected response has arrived, with an idle margin after it.
  task automatic drain();
    hold_off(1);
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write; the write enable is lowered by the next hold-off or command.
  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CFG_SEED) begin
      seed_reg = data;
    end else begin
      count_reg = data[12:0];
      perm_ready = 1'b0;
    end
  endtask

  // Send one command and record its expected response once it is accepted.
  task automatic send_cmd(input opcode_e op, input logic [11:0] pos);
    req_t cmd;
    rsp_t rsp;
    cmd.opcode = op;
    cmd.position = pos;
    cfg_we_i <= 1'b0;
    start <= 1'b1;
    req_i <= cmd;
    do @(posedge clk_i); while (busy);
    predict_rsp(cmd, rsp);
    pending_rsp_q.push_back(rsp);
    items_sent++;
    if (!calm && $urandom_range(3) == 0) hold_off($urandom_range(1, 6));
  endtask

  // Directed corners: reads before shuffle, count saturation, seed extremes.
  task automatic test_directed();
    send_cmd(OP_READ, 12'd0);
    send_cmd(OP_READ, 12'hFFF);
    drain();
    write_reg(CFG_COUNT, 64'd0);
    send_cmd(OP_SHUFFLE, 12'hFFF);
    send_cmd(OP_READ, 12'd0);
    send_cmd(OP_READ, 12'd1);
    send_cmd(OP_READ, 12'hFFF);
    drain();
    write_reg(CFG_SEED, 64'd0);
    write_reg(CFG_COUNT, 64'd5);
    send_cmd(OP_SHUFFLE, 12'd0);
    for (int p = 0; p < 6; p++) send_cmd(OP_READ, p[11:0]);
    drain();
    write_reg(CFG_SEED, '1);
    write_reg(CFG_COUNT, 64'd2);
    send_cmd(OP_SHUFFLE, 12'd0);
    send_cmd(OP_READ, 12'd0);
    send_cmd(OP_READ, 12'd1);
    drain();
    // Count above the table size saturates; a read before shuffling
    // reports not-shuffled even at an out-of-range position.
    write_reg(CFG_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(OP_READ, 12'hFFF);
    send_cmd(OP_SHUFFLE, 12'd0);
    send_cmd(OP_READ, 12'd0);
    send_cmd(OP_READ, 12'hFFF);
    send_cmd(OP_READ, 12'hAAA);
    send_cmd(OP_READ, 12'h555);
    drain();
    // A seed write leaves the current permutation readable.
    write_reg(CFG_SEED, 64'h0123_4567_89AB_CDEF);
    send_cmd(OP_READ, 12'h800);
    drain();
  endtask

  // Random phases: new settings between phases, then a mix of shuffles and reads.
  task automatic test_random(input int target);
    int n;
    int len;
    while (items_sent < target) begin
      drain();
      if ($urandom_range(1) == 0) write_reg(CFG_SEED, {$urandom, $urandom});
      if ($urandom_range(2) != 0) begin
        case ($urandom_range(19))
          0: write_reg(CFG_COUNT, 64'd0);
          1: write_reg(CFG_COUNT, 64'($urandom_range(64, 300)));
          2: write_reg(CFG_COUNT, {$urandom, $urandom});
          default: write_reg(CFG_COUNT, 64'($urandom_range(1, 40)));
        endcase
      end
      // Keep the run short: oversized counts are only read, never shuffled.
      if (active_count() > 300) begin
        send_cmd(OP_READ, 12'($urandom));
        continue;
      end
      n = active_count();
      len = $urandom_range(10, 30);
      if (perm_ready == 0 || $urandom_range(3) != 0) send_cmd(OP_SHUFFLE, 12'($urandom));
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(9) == 0 && n <= 300) begin
          send_cmd(OP_SHUFFLE, 12'($urandom));
        end else begin
          case ($urandom_range(5))
            0: send_cmd(OP_READ, 12'($urandom));
            1: send_cmd(OP_READ, 12'(n + $urandom_range(0, 3)));
            default: send_cmd(OP_READ, 12'($urandom_range(0, n - 1)));
          endcase
        end
      end
    end
  endtask

  // Final stretch with no gaps between commands.
  task automatic test_back_to_back();
    calm = 1'b1;
    drain();
    write_reg(CFG_COUNT, 64'd17);
    send_cmd(OP_SHUFFLE, 12'd0);
    for (int k = 0; k < 40; k++) send_cmd(OP_READ, 12'($urandom_range(0, 20)));
    send_cmd(OP_SHUFFLE, 12'd0);
    send_cmd(OP_READ, 12'd16);
    drain();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SEED;
    cfg_data_i = '0;
    seed_reg = '0;
    count_reg = 13'd1;
    perm_ready = 1'b0;
    error_count = 0;
    items_sent = 0;
    calm = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1950);
    test_back_to_back();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
